// ===== sv/psm_pkg.sv =====
// Shared constants for the patch SSD match score unit.
// Sizes of the map and template stores, action codes and register indexes.
// No dependencies.
package psm_pkg;

    localparam int MAP_PIXELS   = 1048576;
    localparam int ANGLE_COUNT  = 33;
    localparam int MAX_HALF     = 15;

    localparam int PATCH_SIDE   = 2 * MAX_HALF + 1;
    localparam int PATCH_AREA   = PATCH_SIDE * PATCH_SIDE;
    localparam int TMPL_DEPTH   = ANGLE_COUNT * PATCH_AREA;

    localparam int MAP_AW       = $clog2(MAP_PIXELS);
    localparam int TMPL_AW      = $clog2(TMPL_DEPTH);

    // row * width + column with 11-bit row and width
    localparam int LIN_W        = 23;
    localparam int CMP_W        = 26;

    localparam int SUM_W        = 26;

    localparam logic [1:0] ACT_MAP_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TMPL_LOAD = 2'd1;
    localparam logic [1:0] ACT_SCORE     = 2'd2;

    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_HALF_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HALF_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage

// ===== sv/patch_ssd_match_score_unit.sv =====
// Top level of the patch SSD match score unit: map store, template store,
// window sequencer and squared-difference accumulator. Depends on psm_pkg.
//
// Load transactions write one map or template pixel. A
// score transaction issues one window position per cycle, one for each of the
// (2*half_height+1) x (2*half_width+1) positions, then drains the four-stage
// pipeline. The result register loads once the pipeline is empty and the output
// register is free, and the input is ready again from the same clock edge. A
// score takes longer only while an earlier result still waits in the output
// register. Its pace is set by the single read port of the map store and the
// one shared square unit, both used once per window position.
// Pixels outside the map read as 0 and set window_outside. The input is not
// ready while a score is in progress; a finished result waits in the output
// register while the next transaction is taken. Both pixel stores hold
// undefined data until written.
module patch_ssd_match_score_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [19:0] i_map_address,
    input  logic [5:0]  i_angle,
    input  logic signed [4:0] i_patch_dx,
    input  logic signed [4:0] i_patch_dy,
    input  logic [7:0]  i_pixel,
    input  logic [9:0]  i_center_x,
    input  logic [9:0]  i_center_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [25:0] o_match_error,
    output logic        o_window_outside
);

    localparam int MAP_AW  = psm_pkg::MAP_AW;
    localparam int TMPL_AW = psm_pkg::TMPL_AW;
    localparam int LIN_W   = psm_pkg::LIN_W;
    localparam int CMP_W   = psm_pkg::CMP_W;
    localparam int SUM_W   = psm_pkg::SUM_W;

    psm_pkg::t_state r_state, n_state;

    logic [10:0] r_map_width, r_map_height;
    logic [3:0]  r_half_width, r_half_height;

    logic [7:0] r_map_mem  [psm_pkg::MAP_PIXELS];
    logic [7:0] r_tmpl_mem [psm_pkg::TMPL_DEPTH];

    // sequencer
    logic [9:0]         r_cx, r_cy;
    logic [3:0]         r_hw, r_hh;
    logic signed [4:0]  r_dx, r_dy;
    logic [TMPL_AW-1:0] r_abase;

    // stage 1
    logic               r1_v;
    logic signed [11:0] r1_row, r1_col;
    logic [TMPL_AW-1:0] r1_taddr;
    logic               r1_pok;
    // stage 2
    logic               r2_v;
    logic [LIN_W-1:0]   r2_lin;
    logic               r2_oob;
    logic [TMPL_AW-1:0] r2_taddr;
    logic               r2_pok;
    // stage 3
    logic               r3_v;
    logic [7:0]         r3_mv, r3_tv;
    logic               r3_out;
    logic               r3_pok;
    // stage 4
    logic               r4_v;
    logic [15:0]        r4_sq;
    logic               r4_out;

    logic [SUM_W-1:0]   r_sum;
    logic               r_outside;
    logic               r_out_valid;
    logic [25:0]        r_out_err;
    logic               r_out_flag;

    logic               w_accept, w_score, w_map_we, w_tmpl_we;
    logic [5:0]         w_ang_sat;
    logic [TMPL_AW-1:0] w_tmpl_waddr, w_abase, w_taddr;
    logic               w_dx_last, w_dy_last, w_pok, w_out2;
    logic signed [11:0] w_row, w_col;
    logic signed [17:0] w_diff;
    logic [7:0]         w_mv, w_tv;

    assign o_in_ready = (r_state == psm_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_score    = w_accept && (i_action == psm_pkg::ACT_SCORE);

    assign w_map_we = w_accept && (i_action == psm_pkg::ACT_MAP_LOAD) &&
                      (CMP_W'(i_map_address) < CMP_W'(psm_pkg::MAP_PIXELS));
    assign w_tmpl_we = w_accept && (i_action == psm_pkg::ACT_TMPL_LOAD) &&
                       (int'(i_angle) < psm_pkg::ANGLE_COUNT) &&
                       (int'(i_patch_dx) >= -psm_pkg::MAX_HALF) &&
                       (int'(i_patch_dx) <= psm_pkg::MAX_HALF) &&
                       (int'(i_patch_dy) >= -psm_pkg::MAX_HALF) &&
                       (int'(i_patch_dy) <= psm_pkg::MAX_HALF);
    assign w_tmpl_waddr = TMPL_AW'(int'(i_angle) * psm_pkg::PATCH_AREA +
                          (int'(i_patch_dy) + psm_pkg::MAX_HALF) * psm_pkg::PATCH_SIDE +
                          int'(i_patch_dx) + psm_pkg::MAX_HALF);

    assign w_ang_sat = (int'(i_angle) >= psm_pkg::ANGLE_COUNT) ?
                       6'(psm_pkg::ANGLE_COUNT - 1) : i_angle;
    assign w_abase   = TMPL_AW'(int'(w_ang_sat) * psm_pkg::PATCH_AREA);

    // window position issue
    assign w_dx_last = (r_dx == $signed({1'b0, r_hw}));
    assign w_dy_last = (r_dy == $signed({1'b0, r_hh}));
    assign w_row     = $signed({2'b00, r_cy}) + {{7{r_dy[4]}}, r_dy};
    assign w_col     = $signed({2'b00, r_cx}) + {{7{r_dx[4]}}, r_dx};
    assign w_pok     = (int'(r_dx) >= -psm_pkg::MAX_HALF) &&
                       (int'(r_dx) <= psm_pkg::MAX_HALF) &&
                       (int'(r_dy) >= -psm_pkg::MAX_HALF) &&
                       (int'(r_dy) <= psm_pkg::MAX_HALF);
    assign w_taddr   = TMPL_AW'(int'(r_abase) +
                       (int'(r_dy) + psm_pkg::MAX_HALF) * psm_pkg::PATCH_SIDE +
                       int'(r_dx) + psm_pkg::MAX_HALF);

    assign w_out2 = r2_oob || (CMP_W'(r2_lin) >= CMP_W'(psm_pkg::MAP_PIXELS));

    assign w_mv   = r3_out ? 8'd0 : r3_mv;
    assign w_tv   = r3_pok ? r3_tv : 8'd0;
    assign w_diff = $signed({10'd0, w_mv}) - $signed({10'd0, w_tv});

    always_comb begin
        n_state = r_state;
        case (r_state)
            psm_pkg::ST_IDLE: begin
                if (w_score) n_state = psm_pkg::ST_RUN;
            end
            psm_pkg::ST_RUN: begin
                if (w_dx_last && w_dy_last) n_state = psm_pkg::ST_DRAIN;
            end
            psm_pkg::ST_DRAIN: begin
                if (!r1_v && !r2_v && !r3_v && !r4_v) n_state = psm_pkg::ST_DONE;
            end
            psm_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = psm_pkg::ST_IDLE;
            end
            default: n_state = psm_pkg::ST_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= psm_pkg::ST_IDLE;
            r_map_width   <= 11'd1024;
            r_map_height  <= 11'd1024;
            r_half_width  <= 4'd5;
            r_half_height <= 4'd5;
            r1_v          <= 1'b0;
            r2_v          <= 1'b0;
            r3_v          <= 1'b0;
            r4_v          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    psm_pkg::CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                    psm_pkg::CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                    psm_pkg::CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[3:0];
                    psm_pkg::CFG_HALF_HEIGHT: r_half_height <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            r1_v <= (r_state == psm_pkg::ST_RUN);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            if (r_state == psm_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (w_score) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_hw    <= r_half_width;
            r_hh    <= r_half_height;
            r_dx    <= -$signed({1'b0, r_half_width});
            r_dy    <= -$signed({1'b0, r_half_height});
            r_abase <= w_abase;
        end else if (r_state == psm_pkg::ST_RUN) begin
            if (w_dx_last) begin
                r_dx <= -$signed({1'b0, r_hw});
                r_dy <= r_dy + 5'sd1;
            end else begin
                r_dx <= r_dx + 5'sd1;
            end
        end

        r1_row   <= w_row;
        r1_col   <= w_col;
        r1_taddr <= w_taddr;
        r1_pok   <= w_pok;

        r2_oob   <= r1_row[11] || r1_col[11] ||
                    (r1_row[10:0] >= r_map_height) || (r1_col[10:0] >= r_map_width);
        r2_lin   <= LIN_W'({11'd0, r1_row[10:0]} * {11'd0, r_map_width}) +
                    LIN_W'(r1_col[10:0]);
        r2_taddr <= r1_taddr;
        r2_pok   <= r1_pok;

        r3_out <= w_out2;
        r3_pok <= r2_pok;

        r4_sq  <= 16'(w_diff * w_diff);
        r4_out <= r3_out;

        if (w_score) begin
            r_sum     <= '0;
            r_outside <= 1'b0;
        end else if (r4_v) begin
            r_sum     <= r_sum + SUM_W'(r4_sq);
            r_outside <= r_outside | r4_out;
        end

        if (r_state == psm_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_err  <= 26'(r_sum + SUM_W'(1));
            r_out_flag <= r_outside;
        end
    end

    // map store
    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map_mem[MAP_AW'(i_map_address)] <= i_pixel;
        r3_mv <= r_map_mem[MAP_AW'(r2_lin)];
    end

    // template store
    always_ff @(posedge i_clk) begin
        if (w_tmpl_we) r_tmpl_mem[w_tmpl_waddr] <= i_pixel;
        r3_tv <= r_tmpl_mem[r2_taddr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_error    = r_out_err;
    assign o_window_outside = r_out_flag;

endmodule

// ===== dv/tb_patch_ssd_match_score_unit.sv =====
// Testbench for patch_ssd_match_score_unit: map and template pixel loads followed by
// window scores, each result checked field by field against an in-bench SSD scoreboard.
// Depends on psm_pkg and the patch_ssd_match_score_unit RTL.
module tb_patch_ssd_match_score_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_TARGET   = 550;
    localparam int SETTLE_CYCLES = 1000;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int BLOCK_PICKS   = 15;

    typedef struct {
        logic [1:0]        action;
        logic [19:0]       map_address;
        logic [5:0]        angle;
        logic signed [4:0] patch_dx;
        logic signed [4:0] patch_dy;
        logic [7:0]        pixel;
        logic [9:0]        center_x;
        logic [9:0]        center_y;
    } t_txn;

    typedef struct {
        logic [25:0] match_error;
        logic        window_outside;
    } t_score;

    class ssd_score_model;
        bit [7:0]    map_px [int];
        bit [7:0]    tmpl_px [psm_pkg::TMPL_DEPTH];
        bit          tmpl_set [psm_pkg::TMPL_DEPTH];
        logic [10:0] map_w;
        logic [10:0] map_h;
        logic [3:0]  half_w;
        logic [3:0]  half_h;
        t_score      expected_scores [$];
        int          fails;

        function new();
            map_w  = 11'd1024;
            map_h  = 11'd1024;
            half_w = 4'd5;
            half_h = 4'd5;
            fails  = 0;
        endfunction

        function int tmpl_index(int ang, int dx, int dy);
            return (ang * psm_pkg::PATCH_SIDE + dy + psm_pkg::MAX_HALF) * psm_pkg::PATCH_SIDE +
                   dx + psm_pkg::MAX_HALF;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                psm_pkg::CFG_MAP_WIDTH:   map_w  = val;
                psm_pkg::CFG_MAP_HEIGHT:  map_h  = val;
                psm_pkg::CFG_HALF_WIDTH:  half_w = val[3:0];
                psm_pkg::CFG_HALF_HEIGHT: half_h = val[3:0];
                default: ;
            endcase
        endfunction

        function t_score window_ssd(int cx, int cy, int ang);
            logic [31:0] sum;
            int          row, col, mv, tv, diff;
            longint      lin;
            t_score      s;
            sum = '0;
            s.window_outside = 1'b0;
            if (ang >= psm_pkg::ANGLE_COUNT) ang = psm_pkg::ANGLE_COUNT - 1;
            for (int dy = -int'(half_h); dy <= int'(half_h); dy++) begin
                for (int dx = -int'(half_w); dx <= int'(half_w); dx++) begin
                    row = cy + dy;
                    col = cx + dx;
                    mv  = 0;
                    tv  = 0;
                    if (row < 0 || col < 0 || row >= int'(map_h) || col >= int'(map_w)) begin
                        s.window_outside = 1'b1;
                    end else begin
                        lin = longint'(row) * longint'(map_w) + longint'(col);
                        if (lin >= psm_pkg::MAP_PIXELS) s.window_outside = 1'b1;
                        else if (map_px.exists(int'(lin))) mv = map_px[int'(lin)];
                    end
                    if (dx >= -psm_pkg::MAX_HALF && dx <= psm_pkg::MAX_HALF &&
                        dy >= -psm_pkg::MAX_HALF && dy <= psm_pkg::MAX_HALF)
                        tv = tmpl_px[tmpl_index(ang, dx, dy)];
                    diff = mv - tv;
                    sum += 32'(diff * diff);
                end
            end
            s.match_error = 26'(sum + 32'd1);
            return s;
        endfunction

        function void note_transaction(t_txn t);
            int idx;
            case (t.action)
                psm_pkg::ACT_MAP_LOAD: begin
                    if (int'(t.map_address) < psm_pkg::MAP_PIXELS)
                        map_px[int'(t.map_address)] = t.pixel;
                end
                psm_pkg::ACT_TMPL_LOAD: begin
                    if (int'(t.angle) < psm_pkg::ANGLE_COUNT &&
                        t.patch_dx >= -psm_pkg::MAX_HALF && t.patch_dx <= psm_pkg::MAX_HALF &&
                        t.patch_dy >= -psm_pkg::MAX_HALF && t.patch_dy <= psm_pkg::MAX_HALF) begin
                        idx = tmpl_index(t.angle, t.patch_dx, t.patch_dy);
                        tmpl_px[idx]  = t.pixel;
                        tmpl_set[idx] = 1'b1;
                    end
                end
                psm_pkg::ACT_SCORE: begin
                    expected_scores.insert(expected_scores.size(),
                                           window_ssd(t.center_x, t.center_y, t.angle));
                end
                default: ;
            endcase
        endfunction

        function void check_score(logic [25:0] err, logic outside);
            t_score e;
            if (expected_scores.size() == 0) begin
                $error("score result with none pending: match_error %0d window_outside %0d",
                       err, outside);
                fails++;
                return;
            end
            e = expected_scores.pop_front();
            if (err !== e.match_error) begin
                $error("match_error expected %0d actual %0d", e.match_error, err);
                fails++;
            end
            if (outside !== e.window_outside) begin
                $error("window_outside expected %0d actual %0d", e.window_outside, outside);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_txn        drv;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [25:0] match_error;
    logic        window_outside;
    bit          calm = 1'b0;
    int          cycles = 0;
    int          sent = 0;
    ssd_score_model scores;

    patch_ssd_match_score_unit u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (drv.action),
        .i_map_address    (drv.map_address),
        .i_angle          (drv.angle),
        .i_patch_dx       (drv.patch_dx),
        .i_patch_dy       (drv.patch_dy),
        .i_pixel          (drv.pixel),
        .i_center_x       (drv.center_x),
        .i_center_y       (drv.center_y),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_match_error    (match_error),
        .o_window_outside (window_outside)
    );

    always #2 clk = ~clk;

    always @(negedge clk) begin
        out_ready = calm || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) scores.note_transaction(drv);
            if (out_valid && out_ready) scores.check_score(match_error, window_outside);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_txn noise_txn(logic [1:0] act);
        t_txn t;
        t.action      = act;
        t.map_address = 20'($urandom_range(0, 20'hFFFFF));
        t.angle       = 6'($urandom_range(0, 63));
        t.patch_dx    = 5'($urandom_range(0, 31));
        t.patch_dy    = 5'($urandom_range(0, 31));
        t.pixel       = 8'($urandom_range(0, 255));
        t.center_x    = 10'($urandom_range(0, 1023));
        t.center_y    = 10'($urandom_range(0, 1023));
        return t;
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 3))
            0:       return 1024;
            1:       return $urandom_range(1, 64);
            default: return $urandom_range(1, 2047);
        endcase
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int clip_coord(int v);
        if (v < 0) return 0;
        if (v > 1023) return 1023;
        return v;
    endfunction

    task automatic send(t_txn t);
        if (!calm && $urandom_range(0, 99) < 32) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        drv      = t;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_map(int lin, logic [7:0] pix);
        t_txn t;
        t = noise_txn(psm_pkg::ACT_MAP_LOAD);
        t.map_address = lin[19:0];
        t.pixel       = pix;
        send(t);
    endtask

    task automatic send_tmpl(int ang, int dx, int dy, logic [7:0] pix);
        t_txn t;
        t = noise_txn(psm_pkg::ACT_TMPL_LOAD);
        t.angle    = 6'(ang);
        t.patch_dx = 5'(dx);
        t.patch_dy = 5'(dy);
        t.pixel    = pix;
        send(t);
    endtask

    // Loads each map and template pixel the window will read that is not yet set, then scores it.
    // With fill_extreme set, all of them are rewritten: map 255, template 0.
    task automatic score_window(int cx, int cy, int ang, bit fill_extreme = 1'b0);
        t_txn   t;
        int     a, row, col;
        longint lin;
        a = (ang >= psm_pkg::ANGLE_COUNT) ? psm_pkg::ANGLE_COUNT - 1 : ang;
        for (int dy = -int'(scores.half_h); dy <= int'(scores.half_h); dy++) begin
            for (int dx = -int'(scores.half_w); dx <= int'(scores.half_w); dx++) begin
                if (fill_extreme || !scores.tmpl_set[scores.tmpl_index(a, dx, dy)])
                    send_tmpl(a, dx, dy, fill_extreme ? 8'h00 : rand_pixel());
                row = cy + dy;
                col = cx + dx;
                if (row >= 0 && col >= 0 && row < int'(scores.map_h) &&
                    col < int'(scores.map_w)) begin
                    lin = longint'(row) * longint'(scores.map_w) + longint'(col);
                    if (lin < psm_pkg::MAP_PIXELS &&
                        (fill_extreme || !scores.map_px.exists(int'(lin))))
                        send_map(int'(lin), fill_extreme ? 8'hFF : rand_pixel());
                end
            end
        end
        t = noise_txn(psm_pkg::ACT_SCORE);
        t.center_x = 10'(cx);
        t.center_y = 10'(cy);
        t.angle    = 6'(ang);
        send(t);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (scores.expected_scores.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [10:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        scores.set_reg(idx, val);
    endtask

    task automatic configure(int w, int h, int hw, int hh);
        drain();
        cfg_write(psm_pkg::CFG_MAP_WIDTH, 11'(w));
        cfg_write(psm_pkg::CFG_MAP_HEIGHT, 11'(h));
        cfg_write(psm_pkg::CFG_HALF_WIDTH, {7'($urandom_range(0, 127)), 4'(hw)});
        cfg_write(psm_pkg::CFG_HALF_HEIGHT, {7'($urandom_range(0, 127)), 4'(hh)});
    endtask

    initial begin
        int   phase, hw, hh, cx, cy, pick, spot;
        int   hot_x [3];
        int   hot_y [3];
        int   angs [3];
        bit   big;
        t_txn t;

        phase   = 0;
        scores  = new();
        drv     = noise_txn(ACT_RESERVED);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 1024 x 1024 map, 11 x 11 window, corner mostly off the map
        score_window(1023, 1023, 40);
        score_window(1020, 1022, 32);
        send(noise_txn(ACT_RESERVED));
        t = noise_txn(psm_pkg::ACT_TMPL_LOAD);
        t.angle = 6'd33;
        send(t);
        t = noise_txn(psm_pkg::ACT_TMPL_LOAD);
        t.angle    = 6'd5;
        t.patch_dx = 5'b10000;
        send(t);
        t = noise_txn(psm_pkg::ACT_TMPL_LOAD);
        t.angle    = 6'd2;
        t.patch_dy = 5'b10000;
        send(t);
        send_map(psm_pkg::MAP_PIXELS - 1, 8'hFF);
        send_map(0, 8'h00);

        configure(1, 1, 0, 0);
        score_window(0, 0, 1);
        score_window(1, 0, 1);
        score_window(0, 1, 63);

        // rows past the linear store end while still inside width and height
        configure(2047, 2047, 1, 1);
        score_window(1023, 600, 2);
        score_window(3, 3, 2);
        configure(1024, 2047, 1, 1);
        score_window(500, 1023, 3);

        // widest half sizes, one axis at a time
        configure(1024, 1024, 15, 0);
        score_window(500, 500, 63, 1'b1);
        configure(1024, 1024, 0, 15);
        score_window(0, 0, 32);

        while (sent < ITEM_TARGET) begin
            big = ($urandom_range(0, 7) == 0);
            if (big && $urandom_range(0, 1) == 0) begin
                hw = $urandom_range(8, 15);
                hh = $urandom_range(0, 1);
            end else if (big) begin
                hw = $urandom_range(0, 1);
                hh = $urandom_range(8, 15);
            end else begin
                hw = $urandom_range(0, 2);
                hh = $urandom_range(0, 2);
            end
            configure(pick_dim(), pick_dim(), hw, hh);
            for (int i = 0; i < 3; i++) begin
                hot_x[i] = pick_coord();
                hot_y[i] = pick_coord();
                angs[i]  = $urandom_range(0, 63);
            end
            calm = (phase == 0);
            for (int k = 0; k < BLOCK_PICKS && sent < ITEM_TARGET; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    if (!big && $urandom_range(0, 4) == 0) begin
                        cx = $urandom_range(0, 1023);
                        cy = $urandom_range(0, 1023);
                    end else begin
                        spot = $urandom_range(0, 2);
                        cx = clip_coord(hot_x[spot] + int'($urandom_range(0, 4)) - 2);
                        cy = clip_coord(hot_y[spot] + int'($urandom_range(0, 4)) - 2);
                    end
                    score_window(cx, cy, angs[$urandom_range(0, 2)]);
                end else if (pick < 75) begin
                    t = noise_txn(psm_pkg::ACT_MAP_LOAD);
                    t.pixel = rand_pixel();
                    send(t);
                end else if (pick < 92) begin
                    t = noise_txn(psm_pkg::ACT_TMPL_LOAD);
                    send(t);
                end else begin
                    send(noise_txn(ACT_RESERVED));
                end
            end
            calm = 1'b0;
            phase++;
        end

        drain();
        if (scores.fails == 0 && scores.expected_scores.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
